>>> hdl/msh_pkg.sv
// Shared types and constants for the multiply-shift hash collision checker.
// No dependencies; imported by every module of the block.
package msh_pkg;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = 32;
    localparam int IDX_BITS_W  = 4;
    localparam int IDX_W       = 12;
    localparam int EPOCH_W     = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;

    // Widest index the product may supply; larger settings saturate here.
    localparam logic [IDX_BITS_W-1:0] MAX_INDEX_BITS = 4'd12;
    localparam logic [IDX_BITS_W-1:0] INDEX_BITS_RST = 4'd12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULTIPLIER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS      = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } msh_q_status_t;

endpackage

>>> hdl/msh_queue.sv
// Small FIFO between the hashing front end and the table back end.
// Depends on msh_pkg for the status struct.
module msh_queue #(
    parameter int WIDTH = 77,
    parameter int DEPTH = msh_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      head_data,
    output msh_pkg::msh_q_status_t status
);
    import msh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data    = entries[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

endmodule

>>> hdl/msh_front.sv
// Front end: takes a beat, forms the hashed slot index with one shared
// 32x32 multiplier and a reciprocal reduction, then pushes it to the queue.
// Depends on msh_pkg.
module msh_front #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [msh_pkg::WORD_W-1:0]             key,
    input  logic [msh_pkg::WORD_W-1:0]             value,
    input  logic                                   last,
    input  logic [msh_pkg::WORD_W-1:0]             hash_multiplier,
    input  logic [msh_pkg::IDX_BITS_W-1:0]         index_bits,
    input  msh_pkg::msh_q_status_t                 q_status,
    output logic                                   front_busy,
    output logic                                   push,
    output logic [$clog2(TABLE_DEPTH)-1:0]         push_slot,
    output logic [msh_pkg::WORD_W-1:0]             push_value,
    output logic                                   push_last
);
    import msh_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (DEPTH_W > IDX_W) ? DEPTH_W : IDX_W;
    localparam int REC_SH  = 2 * IDX_W;
    // floor(2^REC_SH / depth): quotient estimate is low by at most one
    localparam logic [REC_SH-1:0]  RECIP   = REC_SH'((64'd1 << REC_SH) / TABLE_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_K = DEPTH_W'(TABLE_DEPTH);
    localparam logic [CMP_W-1:0]   DEPTH_C = CMP_W'(TABLE_DEPTH);

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_MUL0 = 4'd1;
    localparam logic [3:0] F_MUL1 = 4'd2;
    localparam logic [3:0] F_MUL2 = 4'd3;
    localparam logic [3:0] F_SUM  = 4'd4;
    localparam logic [3:0] F_IDX  = 4'd5;
    localparam logic [3:0] F_REC  = 4'd6;
    localparam logic [3:0] F_QD   = 4'd7;
    localparam logic [3:0] F_RED  = 4'd8;
    localparam logic [3:0] F_PUSH = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [WORD_W-1:0]   key_reg, key_next;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic                last_reg, last_next;
    logic [WORD_W-1:0]   prod_reg, prod_next;
    logic [HALF_W-1:0]   acc_hi_reg, acc_hi_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    q_reg, q_next;
    logic [IDX_W-1:0]    qd_reg, qd_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic [HALF_W-1:0]       mul_a, mul_b;
    logic [WORD_W-1:0]       mul_p;
    logic [IDX_W+REC_SH-1:0] rec_p;
    logic [IDX_W+DEPTH_W-1:0] qd_p;
    logic [IDX_BITS_W-1:0]   bits_sat;
    logic [IDX_W-1:0]        rem_raw;
    logic [CMP_W-1:0]        rem_ext, rem_red;

    // Shared multiplier: low product word = ll + ((lh + hl) << 32)
    always_comb
    begin
        case (state_reg)
            F_MUL1:
            begin
                mul_a = key_reg[HALF_W-1:0];
                mul_b = hash_multiplier[WORD_W-1:HALF_W];
            end
            F_MUL2:
            begin
                mul_a = key_reg[WORD_W-1:HALF_W];
                mul_b = hash_multiplier[HALF_W-1:0];
            end
            default:
            begin
                mul_a = key_reg[HALF_W-1:0];
                mul_b = hash_multiplier[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign rec_p    = idx_reg * RECIP;
    assign qd_p     = q_reg * DEPTH_K;
    assign bits_sat = (index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_bits;
    assign rem_raw  = idx_reg - qd_reg;
    assign rem_ext  = CMP_W'(rem_raw);
    assign rem_red  = (rem_ext >= DEPTH_C) ? rem_ext - DEPTH_C : rem_ext;

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        prod_next   = prod_reg;
        acc_hi_next = acc_hi_reg;
        idx_next    = idx_reg;
        q_next      = q_reg;
        qd_next     = qd_reg;
        slot_next   = slot_reg;
        push        = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    value_next = value;
                    last_next  = last;
                    state_next = F_MUL0;
                end
            end
            F_MUL0:
            begin
                prod_next  = mul_p;
                state_next = F_MUL1;
            end
            F_MUL1:
            begin
                acc_hi_next = prod_reg[WORD_W-1:HALF_W];
                prod_next   = mul_p;
                state_next  = F_MUL2;
            end
            F_MUL2:
            begin
                acc_hi_next = acc_hi_reg + prod_reg[HALF_W-1:0];
                prod_next   = mul_p;
                state_next  = F_SUM;
            end
            F_SUM:
            begin
                acc_hi_next = acc_hi_reg + prod_reg[HALF_W-1:0];
                state_next  = F_IDX;
            end
            F_IDX:
            begin
                // zero index bits shifts everything out: slot 0
                idx_next   = acc_hi_reg[HALF_W-1 -: IDX_W] >> (MAX_INDEX_BITS - bits_sat);
                state_next = F_REC;
            end
            F_REC:
            begin
                q_next     = rec_p[REC_SH +: IDX_W];
                state_next = F_QD;
            end
            F_QD:
            begin
                qd_next    = qd_p[IDX_W-1:0];
                state_next = F_RED;
            end
            F_RED:
            begin
                slot_next  = rem_red[SLOT_W-1:0];
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        acc_hi_reg <= acc_hi_next;
        idx_reg    <= idx_next;
        q_reg      <= q_next;
        qd_reg     <= qd_next;
        slot_reg   <= slot_next;
    end

    assign front_busy = (state_reg != F_IDLE);
    assign push_slot  = slot_reg;
    assign push_value = value_reg;
    assign push_last  = last_reg;

endmodule

>>> hdl/msh_back.sv
// Back end: slot table with epoch tags, collision check and run result.
// Depends on msh_pkg and the queue status struct.
module msh_back #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  msh_pkg::msh_q_status_t             q_status,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     head_slot,
    input  logic [msh_pkg::WORD_W-1:0]         head_value,
    input  logic                               head_last,
    output logic                               pop,
    output logic                               clearing,
    output logic                               done,
    output logic                               magical
);
    import msh_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int MEM_W  = EPOCH_W + WORD_W;
    localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(TABLE_DEPTH - 1);
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_CHECK = 2'd2;

    // Entry = {epoch tag, value}; tag 0 never matches a live run.
    logic [MEM_W-1:0] table_mem [TABLE_DEPTH];

    logic [1:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               conflict_reg, conflict_next;
    logic               done_reg, done_next;
    logic               magical_reg, magical_next;
    logic [SLOT_W-1:0]  cur_slot_reg;
    logic [WORD_W-1:0]  cur_value_reg;
    logic               cur_last_reg;
    logic [MEM_W-1:0]   rd_data_reg;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic               rd_en;
    logic               hit;
    logic               same;
    logic               conflict_now;

    assign hit          = (rd_data_reg[WORD_W +: EPOCH_W] == epoch_reg);
    assign same         = (rd_data_reg[WORD_W-1:0] == cur_value_reg);
    assign conflict_now = conflict_reg | (hit & ~same);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next    = epoch_reg;
        conflict_next = conflict_reg;
        done_next     = 1'b0;
        magical_next  = magical_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cur_slot_reg;
        mem_wdata     = {epoch_reg, cur_value_reg};
        case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_SLOT)
                begin
                    clr_addr_next = '0;
                    state_next    = B_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                mem_we     = ~hit;
                state_next = B_IDLE;
                if (cur_last_reg)
                begin
                    done_next     = 1'b1;
                    magical_next  = ~conflict_now;
                    conflict_next = 1'b0;
                    if (epoch_reg == EPOCH_MAX)
                    begin
                        epoch_next = EPOCH_FIRST;
                        state_next = B_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
                else
                begin
                    conflict_next = conflict_now;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            epoch_reg    <= EPOCH_FIRST;
            conflict_reg <= 1'b0;
            done_reg     <= 1'b0;
            magical_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            epoch_reg    <= epoch_next;
            conflict_reg <= conflict_next;
            done_reg     <= done_next;
            magical_reg  <= magical_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_slot_reg  <= head_slot;
            cur_value_reg <= head_value;
            cur_last_reg  <= head_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= table_mem[head_slot];
        end
    end

    assign clearing = (state_reg == B_CLEAR);
    assign done     = done_reg;
    assign magical  = magical_reg;

endmodule

>>> hdl/multiply_shift_hash_collision_check_unit.sv
// Top level of the multiply-shift hash collision checker.
// Depends on msh_pkg, msh_front, msh_queue and msh_back.
//
// Usage: configure hash_multiplier and index_bits through the write port
// while the unit is idle, then issue key/value beats with start while busy
// is low; mark the final beat of a run with last. Each key is multiplied by
// hash_multiplier (mod 2^64), the top index_bits bits (saturated at 12,
// zero meaning slot 0) pick a slot, reduced modulo TABLE_DEPTH. An empty
// slot stores the value; a filled slot with a different value marks the run
// as failed. On the last beat, done pulses for exactly one cycle with
// magical = 1 if the run had no conflicting collision; the receiver cannot
// stall it, so sample done/magical every cycle. The front end works on a
// beat in order (accept, three partial products on one shared 32x32
// multiplier and their sum, then index extract and a three-step reciprocal
// reduction, then the queue push, which waits while the queue is full) and
// takes no new beat until that push. The table back end handles each beat
// as a registered read, then check and write, and drains a 2-entry queue
// independently. done rises after the last beat's check, and later when the
// back end is still in a clearing pass. Filled slots are tracked by an 8-bit
// epoch tag stored with each entry, so runs need no table sweep; busy is held
// high during a clearing pass over all TABLE_DEPTH slots after reset and after
// every 255th run, when the epoch counter wraps.
module multiply_shift_hash_collision_check_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [msh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msh_pkg::WORD_W-1:0]        cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [msh_pkg::WORD_W-1:0]        key,
    input  logic [msh_pkg::WORD_W-1:0]        value,
    input  logic                              last,
    output logic                              done,
    output logic                              magical
);
    import msh_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int Q_W    = SLOT_W + WORD_W + 1;

    logic [WORD_W-1:0]     hash_multiplier_reg, hash_multiplier_next;
    logic [IDX_BITS_W-1:0] index_bits_reg, index_bits_next;

    logic                  front_busy;
    logic                  clearing;
    logic                  push;
    logic [SLOT_W-1:0]     push_slot;
    logic [WORD_W-1:0]     push_value;
    logic                  push_last;
    logic                  pop;
    logic [Q_W-1:0]        head_data;
    msh_q_status_t         q_status;

    // Config registers: the user must write them only while idle; the block does not enforce it. No read-back.
    always_comb
    begin
        hash_multiplier_next = hash_multiplier_reg;
        index_bits_next      = index_bits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HASH_MULTIPLIER: hash_multiplier_next = cfg_data;
                CFG_INDEX_BITS:      index_bits_next      = cfg_data[IDX_BITS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_multiplier_reg <= '0;
            index_bits_reg      <= INDEX_BITS_RST;
        end
        else
        begin
            hash_multiplier_reg <= hash_multiplier_next;
            index_bits_reg      <= index_bits_next;
        end
    end

    // No beats taken while the front end works or the table is being swept.
    assign busy = front_busy | clearing;

    msh_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start & ~clearing),
        .key             (key),
        .value           (value),
        .last            (last),
        .hash_multiplier (hash_multiplier_reg),
        .index_bits      (index_bits_reg),
        .q_status        (q_status),
        .front_busy      (front_busy),
        .push            (push),
        .push_slot       (push_slot),
        .push_value      (push_value),
        .push_last       (push_last)
    );

    msh_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_slot, push_value, push_last}),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    msh_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_slot  (head_data[Q_W-1 -: SLOT_W]),
        .head_value (head_data[WORD_W:1]),
        .head_last  (head_data[0]),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .magical    (magical)
    );

endmodule
